@@ rtl/timed_servo_move_interpolator_unit_defines.svh @@
// Assertion macros shared by the servo move interpolator RTL.
`ifndef TIMED_SERVO_MOVE_INTERPOLATOR_UNIT_DEFINES_SVH
`define TIMED_SERVO_MOVE_INTERPOLATOR_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define TSMI_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition leads to a consequence on the following edge.
`define TSMI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tsmi_pkg.sv @@
// Types, constants and helper functions of the servo move interpolator.
package tsmi_pkg;

   localparam int TIME_BITS      = 15;
   localparam int ANGLE_BITS     = 8;
   localparam int QUOT_BITS      = 8;
   localparam int NUM_BITS       = TIME_BITS + ANGLE_BITS;
   localparam int STEP_BITS      = $clog2(QUOT_BITS);
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [ANGLE_BITS-1:0] ANGLE_LIMIT    = 8'd180;
   localparam logic [ANGLE_BITS-1:0] RESET_ANGLE    = 8'd90;
   localparam logic [ANGLE_BITS-1:0] MIN_ANGLE_INIT = 8'd0;
   localparam logic [ANGLE_BITS-1:0] MAX_ANGLE_INIT = 8'd180;
   localparam logic [63:0]           TIME_MAX       = (64'd1 << TIME_BITS) - 64'd1;

   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_POSITION = 2'd1;
   localparam logic [1:0] MODE_TIMED    = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_ANGLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ANGLE = 2'd1;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] angle;
      logic signed [15:0] move_time;
   } req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] servo_angle;
      logic                  moving;
      logic                  finished;
   } rsp_type;

   function automatic logic [ANGLE_BITS-1:0] cap_angle(input logic [ANGLE_BITS-1:0] a);
      return (a > ANGLE_LIMIT) ? ANGLE_LIMIT : a;
   endfunction

   // Clamp to min first, then max, so max wins when the limits cross.
   function automatic logic [ANGLE_BITS-1:0] clamp_angle(
      input logic signed [15:0]     a,
      input logic [ANGLE_BITS-1:0]  lo,
      input logic [ANGLE_BITS-1:0]  hi
   );
      logic signed [16:0] v;
      logic signed [16:0] slo;
      logic signed [16:0] shi;
      v   = {a[15], a};
      slo = signed'({9'b0, lo});
      shi = signed'({9'b0, hi});
      if (v < slo) v = slo;
      if (v > shi) v = shi;
      return v[ANGLE_BITS-1:0];
   endfunction

endpackage

@@ rtl/timed_servo_move_interpolator_unit.sv @@
// Servo move interpolator: timed linear ramp of a servo angle.
//
// Usage
//   req channel (req_valid / req_stall / req_data) carries one item: a
//   millisecond tick, an immediate position, or a timed move. Every item
//   gives exactly one transfer on the rsp channel (rsp_valid / rsp_stall /
//   rsp_data) with the commanded angle, the moving flag and the finished flag.
//   csr port (csr_valid / csr_ready / csr_index / csr_wdata) writes min_angle
//   (index 0) and max_angle (index 1); write it only while the block is idle.
// Flow
//   Every item is decoded and then emitted. A tick that advances a running
//   ramp without ending it also passes a multiply for elapsed*|delta| and the
//   steps of a shared restoring divider stage (one quotient bit a cycle).
//   req_stall is high until the item's result sits in the rsp register, so the
//   block takes no new item before it is through with the previous one.
// Reset
//   Synchronous, active high: angle 90, no ramp, limits 0 and 180, rsp empty.
// Back pressure
//   A held rsp result stays stable under rsp_stall; the next item may be taken
//   meanwhile, but its result waits until the output register frees up.
module timed_servo_move_interpolator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tsmi_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tsmi_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsmi_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [7:0]                          csr_wdata
);
   import tsmi_pkg::*;

   `include "timed_servo_move_interpolator_unit_defines.svh"

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   // control state
   logic [2:0]            state_ff, state_in;
   logic                  active_ff, active_in;
   logic [ANGLE_BITS-1:0] current_ff, current_in;
   logic [ANGLE_BITS-1:0] min_ff, min_in;
   logic [ANGLE_BITS-1:0] max_ff, max_in;
   logic [ANGLE_BITS-1:0] start_ff, start_in;
   logic [ANGLE_BITS-1:0] target_ff, target_in;
   logic [TIME_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0]  duration_ff, duration_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // datapath
   req_type               item_ff, item_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [ANGLE_BITS-1:0] mag_ff, mag_in;
   logic [NUM_BITS-1:0]   rem_ff, rem_in;
   logic [QUOT_BITS-1:0]  quot_ff, quot_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;

   logic                  req_xfer;
   logic                  slot_free;
   logic                  set_now;
   logic [ANGLE_BITS-1:0] clamped;
   logic [63:0]           dur_wide;
   logic [TIME_BITS-1:0]  dur_sat;
   logic [TIME_BITS-1:0]  elapsed_step;
   logic [NUM_BITS-1:0]   den_shift;
   logic                  div_ge;
   logic [NUM_BITS-1:0]   rem_next;
   logic [QUOT_BITS-1:0]  quot_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // decode of the held item
   assign set_now = (item_ff.mode == MODE_POSITION) ||
                    ((item_ff.mode == MODE_TIMED) && (item_ff.move_time <= 16'sd0));
   assign clamped = clamp_angle(item_ff.angle, cap_angle(min_ff), cap_angle(max_ff));
   assign dur_wide = 64'(unsigned'(item_ff.move_time));
   assign dur_sat  = (dur_wide > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                           : dur_wide[TIME_BITS-1:0];
   assign elapsed_step = (elapsed_ff < duration_ff) ? elapsed_ff + TIME_BITS'(1)
                                                     : elapsed_ff;

   // shared divider stage: one restoring step per cycle, quotient msb first
   assign den_shift = NUM_BITS'(duration_ff) << cnt_ff;
   assign div_ge    = (rem_ff >= den_shift);
   assign rem_next  = div_ge ? rem_ff - den_shift : rem_ff;
   assign quot_next = {quot_ff[QUOT_BITS-2:0], div_ge};

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      current_in   = current_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      elapsed_in   = elapsed_ff;
      duration_in  = duration_ff;
      rsp_valid_in = rsp_valid_ff;
      item_in      = item_ff;
      rsp_data_in  = rsp_data_ff;
      done_in      = done_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_ANGLE: min_in = csr_wdata;
            CSR_MAX_ANGLE: max_in = csr_wdata;
            default: ;
         endcase
      end

      // drop the output once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            done_in  = 1'b0;
            state_in = ST_EMIT;
            if (set_now) begin
               active_in  = 1'b0;
               current_in = clamped;
            end else if (item_ff.mode == MODE_TIMED) begin
               start_in    = current_ff;
               target_in   = clamped;
               elapsed_in  = '0;
               duration_in = dur_sat;
               active_in   = 1'b1;
            end else if ((item_ff.mode == MODE_TICK) && active_ff) begin
               elapsed_in = elapsed_step;
               if (elapsed_step >= duration_ff) begin
                  current_in = target_ff;
                  active_in  = 1'b0;
                  done_in    = 1'b1;
               end else begin
                  neg_in   = (target_ff < start_ff);
                  mag_in   = (target_ff < start_ff) ? start_ff - target_ff
                                                    : target_ff - start_ff;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            rem_in   = NUM_BITS'(elapsed_ff) * NUM_BITS'(mag_ff);
            quot_in  = '0;
            cnt_in   = STEP_BITS'(QUOT_BITS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_next;
            quot_in = quot_next;
            cnt_in  = cnt_ff - STEP_BITS'(1);
            if (cnt_ff == '0) begin
               // floor toward minus infinity on a falling ramp
               if (neg_ff) begin
                  current_in = start_ff - quot_next - ANGLE_BITS'(rem_next != '0);
               end else begin
                  current_in = start_ff + quot_next;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.servo_angle = current_ff;
               rsp_data_in.moving      = active_ff;
               rsp_data_in.finished    = done_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         current_ff   <= RESET_ANGLE;
         min_ff       <= MIN_ANGLE_INIT;
         max_ff       <= MAX_ANGLE_INIT;
         start_ff     <= '0;
         target_ff    <= '0;
         elapsed_ff   <= '0;
         duration_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         current_ff   <= current_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         elapsed_ff   <= elapsed_in;
         duration_ff  <= duration_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
      done_ff     <= done_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
   end

   // a running ramp never reaches its duration without ending
   `TSMI_ASSERT_ALWAYS(a_ramp_in_range, !active_ff || (elapsed_ff < duration_ff), "ramp elapsed at or past duration")
   // the commanded angle stays within the servo range
   `TSMI_ASSERT_ALWAYS(a_angle_limit, current_ff <= ANGLE_LIMIT, "commanded angle above limit")
   // an accepted item is decoded on the next cycle
   `TSMI_ASSERT_NEXT(a_accept_exec, req_xfer, state_ff == ST_EXEC, "accepted item not decoded")

endmodule
